@@ rtl/assert_macros.svh @@
// Assertion helpers used by the RTL (included by fms_back)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define FMS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define FMS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fms_pkg.sv @@
package fms_pkg;

	// Input operation codes
	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_END  = 1'b1;

	// Document phases
	localparam logic [2:0] PH_BOM        = 3'd0;
	localparam logic [2:0] PH_FIRST      = 3'd1;
	localparam logic [2:0] PH_HEADER     = 3'd2;
	localparam logic [2:0] PH_BODY_PLAIN = 3'd3;
	localparam logic [2:0] PH_BODY_FRONT = 3'd4;

	// Result section codes
	localparam logic [1:0] SEC_HEADER = 2'd0;
	localparam logic [1:0] SEC_BODY   = 2'd1;
	localparam logic [1:0] SEC_END    = 2'd2;

	// Fence candidate masks
	localparam logic [1:0] FC_NONE = 2'b00;
	localparam logic [1:0] FC_DASH = 2'b01;
	localparam logic [1:0] FC_DOT  = 2'b10;
	localparam logic [1:0] FC_BOTH = 2'b11;

	// Characters of interest
	localparam logic [7:0] CH_DASH = 8'h2D;
	localparam logic [7:0] CH_DOT  = 8'h2E;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;

	// Held line bytes: byte order mark plus fence plus CR
	localparam int HOLD_DEPTH = 7;
	localparam int FENCE_LEN  = 3;
	localparam int BOM_LEN    = 3;

	// Default depth of the command queue
	localparam int QUEUE_DEPTH_DEF = 4;

	// One command: a run of held bytes, then one tail result
	typedef struct packed {
		logic [HOLD_DEPTH-1:0][7:0] held;
		logic [2:0]                 n;
		logic [1:0]                 bsec;
		logic                       present;
		logic [7:0]                 tbyte;
		logic [1:0]                 tsec;
		logic                       tstatus;
	} cmd_t;

	// Byte order mark byte by position
	function automatic logic [7:0] bom_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'hEF;
			2'd1: b = 8'hBB;
			2'd2: b = 8'hBF;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

@@ rtl/front_matter_splitter.sv @@
// Front-matter splitter: takes one document byte per transaction (op 0) or an
// end-of-document transaction (op 1) and emits each byte labelled header or
// body, then an end marker with the fence status. The input side accepts one
// transaction every cycle while the command queue (QUEUE_DEPTH entries) has
// room; the output side delivers one result per cycle from its output
// register unless out_stall holds it. A byte that decides a held line
// releases up to eight results (up to seven held bytes and itself), so the
// result stream, one per cycle from the back unit when not stalled, sets the
// sustained rate, while bytes that are only held produce nothing.
module front_matter_splitter #(
	parameter int QUEUE_DEPTH = fms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic [1:0] section,
	output logic       front_present,
	output logic       status,
	output logic       last
);
	import fms_pkg::*;

	cmd_t push_cmd;
	cmd_t head;
	logic push;
	logic q_full;
	logic q_empty;
	logic pop;

	// Classify bytes and decide lines
	fms_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.push      (push),
		.cmd       (push_cmd),
		.q_full    (q_full)
	);

	// Decouple decisions from result delivery
	fms_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty)
	);

	// Expand commands into results
	fms_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_empty       (q_empty),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.section       (section),
		.front_present (front_present),
		.status        (status),
		.last          (last)
	);

endmodule

@@ rtl/fms_front.sv @@
module fms_front (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_stall,
	input  logic         op,
	input  logic [7:0]   data_byte,
	output logic         push,
	output fms_pkg::cmd_t cmd,
	input  logic         q_full
);
	import fms_pkg::*;

	logic [2:0]                 phase_q, phase_nxt;
	logic [HOLD_DEPTH-1:0][7:0] held_q;
	logic [2:0]                 count_q, count_nxt;
	logic [2:0]                 lp_q, lp_nxt;
	logic [1:0]                 fc_q, fc_nxt;
	logic                       cr_q, cr_nxt;
	logic                       accept;
	logic                       do_hold;
	logic                       emit;
	logic                       bom_match;
	logic                       first_line;
	logic                       is_dash, is_dot, is_cr, is_lf;
	logic [1:0]                 mask;

	// Take a byte whenever the queue has room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && emit;

	assign is_dash = (data_byte == CH_DASH);
	assign is_dot  = (data_byte == CH_DOT);
	assign is_cr   = (data_byte == CH_CR);
	assign is_lf   = (data_byte == CH_LF);
	assign mask    = is_dash ? FC_DASH : FC_DOT;

	assign bom_match  = (count_q < 3'(BOM_LEN)) && (data_byte == bom_byte(count_q[1:0]));
	assign first_line = (phase_q == PH_FIRST)
		|| ((phase_q == PH_BOM) && !bom_match && (count_q == 3'd0));

	// Classify the byte, decide the line and build the command
	always_comb begin
		phase_nxt   = phase_q;
		count_nxt   = count_q;
		lp_nxt      = lp_q;
		fc_nxt      = fc_q;
		cr_nxt      = cr_q;
		do_hold     = 1'b0;
		emit        = 1'b0;
		cmd.held    = held_q;
		cmd.n       = count_q;
		cmd.bsec    = SEC_BODY;
		cmd.present = 1'b0;
		cmd.tbyte   = data_byte;
		cmd.tsec    = SEC_BODY;
		cmd.tstatus = 1'b0;
		if (op == OP_END) begin
			emit      = 1'b1;
			cmd.tbyte = 8'd0;
			cmd.tsec  = SEC_END;
			case (phase_q)
				PH_BOM: begin
					cmd.n = count_q;
				end
				PH_FIRST: begin
					if (lp_q == 3'(FENCE_LEN)) begin
						cmd.n       = 3'd0;
						cmd.present = 1'b1;
						cmd.tstatus = 1'b1;
					end
				end
				PH_HEADER: begin
					cmd.present = 1'b1;
					cmd.bsec    = SEC_HEADER;
					if (fc_q != FC_NONE && lp_q == 3'(FENCE_LEN)) begin
						cmd.n = 3'd0;
					end else begin
						cmd.tstatus = 1'b1;
					end
				end
				PH_BODY_FRONT: begin
					cmd.n       = 3'd0;
					cmd.present = 1'b1;
				end
				default: begin
					cmd.n = 3'd0;
				end
			endcase
			// Return to the start of a new document
			phase_nxt = PH_BOM;
			count_nxt = 3'd0;
			lp_nxt    = 3'd0;
			fc_nxt    = FC_BOTH;
			cr_nxt    = 1'b0;
		end else if (first_line) begin
			// Leave the mark check: this byte belongs to the first line
			phase_nxt = PH_FIRST;
			if (cr_q && is_lf) begin
				phase_nxt = PH_HEADER;
				count_nxt = 3'd0;
				lp_nxt    = 3'd0;
				fc_nxt    = FC_BOTH;
				cr_nxt    = 1'b0;
			end else if (!cr_q && is_dash && lp_q < 3'(FENCE_LEN)) begin
				do_hold   = 1'b1;
				count_nxt = count_q + 3'd1;
				lp_nxt    = lp_q + 3'd1;
			end else if (!cr_q && is_cr && lp_q == 3'(FENCE_LEN)) begin
				do_hold   = 1'b1;
				count_nxt = count_q + 3'd1;
				cr_nxt    = 1'b1;
			end else if (!cr_q && is_lf && lp_q == 3'(FENCE_LEN)) begin
				phase_nxt = PH_HEADER;
				count_nxt = 3'd0;
				lp_nxt    = 3'd0;
				fc_nxt    = FC_BOTH;
				cr_nxt    = 1'b0;
			end else begin
				// Not a fence: everything is body
				emit      = 1'b1;
				phase_nxt = PH_BODY_PLAIN;
				count_nxt = 3'd0;
			end
		end else begin
			case (phase_q)
				PH_BOM: begin
					if (bom_match) begin
						do_hold   = 1'b1;
						count_nxt = count_q + 3'd1;
						if (count_q == 3'(BOM_LEN - 1)) begin
							phase_nxt = PH_FIRST;
						end
					end else begin
						// Partial mark: flush it as body
						emit      = 1'b1;
						phase_nxt = PH_BODY_PLAIN;
						count_nxt = 3'd0;
					end
				end
				PH_HEADER: begin
					cmd.bsec    = SEC_HEADER;
					cmd.tsec    = SEC_HEADER;
					cmd.present = 1'b1;
					if (is_lf) begin
						if (fc_q != FC_NONE && lp_q == 3'(FENCE_LEN)) begin
							// Closing fence: drop it silently
							count_nxt = 3'd0;
							phase_nxt = PH_BODY_FRONT;
						end else begin
							emit      = 1'b1;
							count_nxt = 3'd0;
							lp_nxt    = 3'd0;
							fc_nxt    = FC_BOTH;
							cr_nxt    = 1'b0;
						end
					end else if (!cr_q && fc_q == FC_NONE) begin
						emit  = 1'b1;
						cmd.n = 3'd0;
					end else if (!cr_q && is_cr && lp_q == 3'(FENCE_LEN)) begin
						do_hold   = 1'b1;
						count_nxt = count_q + 3'd1;
						cr_nxt    = 1'b1;
					end else if (!cr_q && (is_dash || is_dot) && lp_q < 3'(FENCE_LEN)
							&& (fc_q & mask) != FC_NONE) begin
						do_hold   = 1'b1;
						count_nxt = count_q + 3'd1;
						lp_nxt    = lp_q + 3'd1;
						fc_nxt    = fc_q & mask;
					end else begin
						// Line is plain header text
						emit      = 1'b1;
						count_nxt = 3'd0;
						fc_nxt    = FC_NONE;
						cr_nxt    = 1'b0;
					end
				end
				PH_BODY_FRONT: begin
					emit        = 1'b1;
					cmd.n       = 3'd0;
					cmd.present = 1'b1;
				end
				default: begin
					emit  = 1'b1;
					cmd.n = 3'd0;
				end
			endcase
		end
	end

	// Advance the line state on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BOM;
			count_q <= 3'd0;
			lp_q    <= 3'd0;
			fc_q    <= FC_BOTH;
			cr_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_nxt;
			count_q <= count_nxt;
			lp_q    <= lp_nxt;
			fc_q    <= fc_nxt;
			cr_q    <= cr_nxt;
		end
	end

	// Hold the byte until its line is decided
	always_ff @(posedge clk) begin
		if (accept && do_hold && count_q != 3'(HOLD_DEPTH)) begin
			held_q[count_q] <= data_byte;
		end
	end

endmodule

@@ rtl/fms_queue.sv @@
module fms_queue #(
	parameter int DEPTH = fms_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  fms_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output fms_pkg::cmd_t head,
	output logic          empty
);
	import fms_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign head    = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Store the command
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

endmodule

@@ rtl/fms_back.sv @@
`include "assert_macros.svh"

module fms_back (
	input  logic          clk,
	input  logic          arst_n,
	input  fms_pkg::cmd_t head,
	input  logic          q_empty,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    out_byte,
	output logic [1:0]    section,
	output logic          front_present,
	output logic          status,
	output logic          last
);
	import fms_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_sec_q;
	logic       out_present_q;
	logic       out_status_q;
	logic       out_last_q;
	logic       load;
	logic       at_tail;

	// Load a new result when the output register is free or draining
	assign load    = !q_empty && (!out_valid_q || !out_stall);
	assign at_tail = (idx_q >= head.n);
	assign pop     = load && at_tail;

	// Walk the held bytes, then the tail
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 3'd0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= at_tail ? 3'd0 : idx_q + 3'd1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q    <= at_tail ? head.tbyte : head.held[idx_q];
			out_sec_q     <= at_tail ? head.tsec : head.bsec;
			out_present_q <= head.present;
			out_status_q  <= at_tail ? head.tstatus : 1'b0;
			out_last_q    <= at_tail;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign section       = out_sec_q;
	assign front_present = out_present_q;
	assign status        = out_status_q;
	assign last          = out_last_q;

	`FMS_ASSERT_IMPL(a_idx_in_range, clk, arst_n, !q_empty, idx_q <= head.n, "held index past run")
	`FMS_ASSERT_IMPL(a_idx_has_cmd, clk, arst_n, idx_q != 3'd0, !q_empty, "run open with empty queue")
	`FMS_ASSERT_IMPL(a_end_is_last, clk, arst_n, out_valid_q && out_sec_q == SEC_END, out_last_q && out_byte_q == 8'd0, "end marker not final")
	`FMS_ASSERT_NEXT(a_run_advances, clk, arst_n, load && !at_tail, idx_q != 3'd0 && out_valid_q && !out_last_q, "held run did not advance")

endmodule
